// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// types and codes shared by the go-back-n controller and datapath
// ----------------------------------------------------------------------------
package gbn_pkg;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_CKSUM   = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_STATUS  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STATUS,
    OP_SEND_NEW,
    OP_DELIVER,
    OP_STOP,
    OP_RESEND_START,
    OP_RESEND
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACK,
    ST_RESEND
  } state_t;

  typedef struct packed {
    logic capture;
    op_t  op;
    logic last;
    logic net_en;
    logic dropped;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  ne_now;
    logic  ne_after_send;
    logic  seq_match;
    logic  ack_any;
    logic  ack_more;
    logic  count_zero;
    logic  resend_last;
  } dp_status_t;

endpackage

// ===== rtl/gbn_dpath.sv =====
// ----------------------------------------------------------------------------
// gbn_dpath
// window registers, packet store, input capture and result registers
// ----------------------------------------------------------------------------
module gbn_dpath #(
  parameter int SEQ_MAX      = 7,
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_W        = $clog2(SEQ_MAX + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gbn_pkg::dp_cmd_t         cmd,
  output gbn_pkg::dp_status_t      status,
  input  logic [1:0]               in_kind,
  input  logic [PAYLOAD_BITS-1:0]  in_tx_payload,
  input  logic [SEQ_W-1:0]         in_rx_seq,
  input  logic [SEQ_W-1:0]         in_rx_ack,
  input  logic [PAYLOAD_BITS-1:0]  in_rx_payload,
  output logic                     out_valid,
  output logic [1:0]               out_action,
  output logic [SEQ_W-1:0]         out_frame_seq,
  output logic [SEQ_W-1:0]         out_frame_ack,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic                     out_network_enable,
  output logic                     out_dropped_full,
  output logic                     out_last
);
  import gbn_pkg::*;

  localparam int DEPTH = SEQ_MAX + 1;
  localparam logic [SEQ_W-1:0] SMAX = SEQ_W'(SEQ_MAX);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    seq_inc = (s == SMAX) ? '0 : s + 1'b1;
  endfunction

  // a <= b < c, circular
  function automatic logic in_win(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
                                  input logic [SEQ_W-1:0] c);
    in_win = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  logic [SEQ_W-1:0]        next_r, oldest_r, expected_r, count_r, remain_r;
  kind_t                   kind_r;
  logic [PAYLOAD_BITS-1:0] tx_r, rx_pay_r, rd_data_r;
  logic [SEQ_W-1:0]        rx_seq_r, rx_ack_r;
  logic [PAYLOAD_BITS-1:0] store_mem [DEPTH];
  logic [SEQ_W-1:0]        rd_addr;
  logic                    ack_ok, emit;
  logic [SEQ_W-1:0]        piggy_ack;

  logic                    out_valid_r, out_ne_r, out_drop_r, out_last_r;
  action_t                 out_action_r, res_action;
  logic [SEQ_W-1:0]        out_seq_r, out_ack_r, res_seq, res_ack;
  logic [PAYLOAD_BITS-1:0] out_pay_r, res_pay;

  assign ack_ok    = (rx_ack_r <= SMAX);
  assign piggy_ack = (expected_r == '0) ? SMAX : expected_r - 1'b1;
  assign rd_addr   = (cmd.op == OP_RESEND_START) ? oldest_r : seq_inc(next_r);

  always_comb begin
    status.kind          = kind_r;
    status.full          = (count_r >= SMAX);
    status.ne_now        = (count_r < SMAX);
    status.ne_after_send = (count_r < SEQ_W'(SEQ_MAX - 1));
    status.seq_match     = (rx_seq_r == expected_r);
    status.ack_any       = ack_ok && (count_r != '0) && in_win(oldest_r, rx_ack_r, next_r);
    status.ack_more      = ack_ok && (count_r > SEQ_W'(1)) &&
                           in_win(seq_inc(oldest_r), rx_ack_r, next_r);
    status.count_zero    = (count_r == '0);
    status.resend_last   = (remain_r == SEQ_W'(1));
  end

  // result fields per operation
  always_comb begin
    emit       = 1'b1;
    res_action = ACT_STATUS;
    res_seq    = '0;
    res_ack    = '0;
    res_pay    = '0;
    case (cmd.op)
      OP_STATUS: begin
      end
      OP_SEND_NEW: begin
        res_action = ACT_SEND;
        res_seq    = next_r;
        res_ack    = piggy_ack;
        res_pay    = tx_r;
      end
      OP_RESEND: begin
        res_action = ACT_SEND;
        res_seq    = next_r;
        res_ack    = piggy_ack;
        res_pay    = rd_data_r;
      end
      OP_DELIVER: begin
        res_action = ACT_DELIVER;
        res_pay    = rx_pay_r;
      end
      OP_STOP: begin
        res_action = ACT_STOP;
        res_seq    = oldest_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r      <= '0;
      oldest_r    <= '0;
      expected_r  <= '0;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      case (cmd.op)
        OP_SEND_NEW: begin
          next_r  <= seq_inc(next_r);
          count_r <= count_r + 1'b1;
        end
        OP_DELIVER: begin
          expected_r <= seq_inc(expected_r);
        end
        OP_STOP: begin
          oldest_r <= seq_inc(oldest_r);
          count_r  <= count_r - 1'b1;
        end
        OP_RESEND_START: begin
          next_r   <= oldest_r;
          remain_r <= count_r;
        end
        OP_RESEND: begin
          next_r   <= seq_inc(next_r);
          remain_r <= remain_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // input capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind_t'(in_kind);
      tx_r     <= in_tx_payload;
      rx_seq_r <= in_rx_seq;
      rx_ack_r <= in_rx_ack;
      rx_pay_r <= in_rx_payload;
    end
    out_action_r <= res_action;
    out_seq_r    <= res_seq;
    out_ack_r    <= res_ack;
    out_pay_r    <= res_pay;
    out_ne_r     <= cmd.net_en;
    out_drop_r   <= cmd.dropped;
    out_last_r   <= cmd.last;
  end

  // packet store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SEND_NEW) begin
      store_mem[next_r] <= tx_r;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_frame_seq      = out_seq_r;
  assign out_frame_ack      = out_ack_r;
  assign out_payload        = out_pay_r;
  assign out_network_enable = out_ne_r;
  assign out_dropped_full   = out_drop_r;
  assign out_last           = out_last_r;

  `include "assert_macros.svh"

  `AST_IMP(a_count_bound, 1'b1, count_r <= SMAX)
  `AST_IMP(a_stop_frees, out_valid_r && out_action_r == ACT_STOP, count_r + 1'b1 == $past(count_r))
  `AST_IMP(a_send_outstanding, out_valid_r && out_action_r == ACT_SEND, count_r != '0)

endmodule

// ===== rtl/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// event sequencer: dispatches each event and steps ack and resend runs
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  gbn_pkg::dp_status_t  status,
  output gbn_pkg::dp_cmd_t     cmd
);
  import gbn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    cmd.last    = 1'b1;
    cmd.net_en  = status.ne_now;
    cmd.dropped = 1'b0;
    busy        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        case (status.kind)
          KIND_SEND: begin
            if (status.full) begin
              cmd.op      = OP_STATUS;
              cmd.dropped = 1'b1;
            end else begin
              cmd.op     = OP_SEND_NEW;
              cmd.net_en = status.ne_after_send;
            end
          end
          KIND_FRAME: begin
            // any freed frame leaves room in the window
            cmd.net_en = status.ne_now | status.ack_any;
            if (status.seq_match) begin
              cmd.op   = OP_DELIVER;
              cmd.last = !status.ack_any;
            end else if (!status.ack_any) begin
              cmd.op = OP_STATUS;
            end
            if (status.ack_any) begin
              state_nxt = ST_ACK;
            end
          end
          KIND_TIMEOUT: begin
            if (status.count_zero) begin
              cmd.op = OP_STATUS;
            end else begin
              cmd.op    = OP_RESEND_START;
              state_nxt = ST_RESEND;
            end
          end
          default: begin
            cmd.op = OP_STATUS;
          end
        endcase
      end
      ST_ACK: begin
        cmd.op     = OP_STOP;
        cmd.net_en = 1'b1;
        cmd.last   = !status.ack_more;
        if (!status.ack_more) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESEND: begin
        cmd.op   = OP_RESEND;
        cmd.last = status.resend_last;
        if (status.resend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `include "assert_macros.svh"

  `AST_NXT(a_accept_dispatch, start && !busy, state_r == ST_DISPATCH)
  `AST_IMP(a_dispatch_src, state_r == ST_DISPATCH, $past(state_r) == ST_IDLE)
  `AST_IMP(a_ack_src, state_r == ST_ACK, $past(state_r) == ST_DISPATCH || $past(state_r) == ST_ACK)

endmodule

// ===== rtl/go_back_n_link_endpoint.sv =====
// ----------------------------------------------------------------------------
// go_back_n_link_endpoint
// go-back-n sliding-window link endpoint with sequence numbers modulo SEQ_MAX+1
// ----------------------------------------------------------------------------
// an event is taken when start is high and busy is low; busy then stays high
// through the dispatch state and through any stop-timer or resend run that
// follows. the result register takes one beat per cycle, and the packet
// store's registered read is preloaded by a timeout in its dispatch state.
// every beat is registered and shows the cycle after it is decided: a send,
// deliver or status beat shows the cycle after dispatch, then stop-timer or
// resend beats follow one per cycle. an arrival that acks without
// delivering, and a timeout with frames outstanding, make nothing in
// dispatch, so their first beat is decided in the ack or resend state. the
// last beat of an event shows in the same cycle that busy falls. each beat
// is marked by a one-cycle out_valid pulse; the receiver cannot stall, so
// every pulse must be taken when it appears. out_last flags the final beat
// of an event and every beat carries the network-enable level that holds
// once the event is done. a packet offered with a full window gives a
// single status beat with out_dropped_full set. the packet store has no
// reset: a resend only reads entries written by earlier sends.
// ----------------------------------------------------------------------------
module go_back_n_link_endpoint #(
  parameter int SEQ_MAX      = 7,
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_W        = $clog2(SEQ_MAX + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // event input
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic [PAYLOAD_BITS-1:0]  in_tx_payload,
  input  logic [SEQ_W-1:0]         in_rx_seq,
  input  logic [SEQ_W-1:0]         in_rx_ack,
  input  logic [PAYLOAD_BITS-1:0]  in_rx_payload,
  // result beats
  output logic                     out_valid,
  output logic [1:0]               out_action,
  output logic [SEQ_W-1:0]         out_frame_seq,
  output logic [SEQ_W-1:0]         out_frame_ack,
  output logic [PAYLOAD_BITS-1:0]  out_payload,
  output logic                     out_network_enable,
  output logic                     out_dropped_full,
  output logic                     out_last
);
  import gbn_pkg::*;

  // controller to datapath commands and status back
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: dispatch, ack run and resend run
  gbn_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // window state, packet store and result registers
  gbn_dpath #(
    .SEQ_MAX      (SEQ_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SEQ_W        (SEQ_W)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (in_kind),
    .in_tx_payload      (in_tx_payload),
    .in_rx_seq          (in_rx_seq),
    .in_rx_ack          (in_rx_ack),
    .in_rx_payload      (in_rx_payload),
    .out_valid          (out_valid),
    .out_action         (out_action),
    .out_frame_seq      (out_frame_seq),
    .out_frame_ack      (out_frame_ack),
    .out_payload        (out_payload),
    .out_network_enable (out_network_enable),
    .out_dropped_full   (out_dropped_full),
    .out_last           (out_last)
  );

endmodule
